@@ rtl/fra_pkg.sv @@
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types and constants for the fragment reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package fra_pkg;

  localparam int SLOTS     = 8;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int MAX_FRAG  = 32;
  localparam int IDX_W     = $clog2(MAX_FRAG);
  localparam int TOTAL_W   = 6;
  localparam int KEY_W     = 64;
  localparam int TIME_W    = 48;
  localparam int HANDLE_W  = 16;
  localparam int TMO_W     = 32;
  localparam int ADDR_W    = SLOT_W + IDX_W;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd1200000000;

  typedef enum logic [1:0] {
    ST_PROGRESS  = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_ERROR     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPIRE,
    S_SCAN,
    S_UPDATE,
    S_EMIT_RD,
    S_EMIT_LD,
    S_WAIT
  } fsm_t;

  // Command broadcast to every slot cell
  typedef struct packed {
    logic                expire;
    logic                update;
    logic                alloc;
    logic                total_ok;
    logic [TOTAL_W-1:0]  total_in;
    logic [MAX_FRAG-1:0] frag_bit;
  } cell_cmd_t;

  // Status returned by a slot cell
  typedef struct packed {
    logic               valid;
    logic               match;
    logic [TIME_W-1:0]  first_time;
    logic               dup;
    logic               complete;
    logic [TOTAL_W-1:0] new_total;
  } cell_stat_t;

endpackage
`default_nettype wire

@@ rtl/fragment_reassembly_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_unit
// Tracks out-of-order message fragments in eight slots and emits the
// buffer handles of a message in order once every fragment is present.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one fragment per transaction (fields listed at the port).
//   m_axis returns results; tlast marks the final result of a fragment.
//   cfg_* writes timeout_us; write it only while the unit is idle.
//   One fragment is worked on at a time. A fragment is accepted, passes
//   expiry, a slot scan of one to eight slots (one slot per cycle) and the
//   update; a fragment that does not complete a message then shows its
//   single result until it is taken. A completed message emits its handles
//   from the handle memory in order, each through read, load and show
//   steps and the receiver's wait.
//   A bad fragment number answers directly with an error, with no scan.
//   Reset frees all slots and loads timeout_us with 1200000000; no
//   clearing pass is needed. When the receiver stalls, the result is held
//   in the output register and s_axis_tready stays low until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module fragment_reassembly_tracker_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // registration_key[63:0], conversation_key[127:64], fragment_number[133:128],
  // message_total[139:134], fragment_handle[155:140], now_time[203:156]
  input  wire logic [207:0]                 s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // status[1:0], slot[4:2], out_index[9:5], out_handle[25:10]
  output logic [31:0]                       m_axis_tdata,
  output logic                              m_axis_tlast,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [fra_pkg::TMO_W-1:0]    cfg_data
);
  import fra_pkg::*;

  fsm_t state, state_next;

  logic [TMO_W-1:0]    timeout;
  logic [KEY_W-1:0]    in_reg;
  logic [KEY_W-1:0]    in_conv;
  logic [IDX_W-1:0]    in_idx;
  logic                in_total_ok;
  logic [TOTAL_W-1:0]  in_total;
  logic [HANDLE_W-1:0] in_handle;
  logic [TIME_W-1:0]   in_now;

  logic [SLOT_W-1:0]   scan;
  logic                have_empty;
  logic [SLOT_W-1:0]   empty_idx;
  logic                have_old;
  logic [SLOT_W-1:0]   old_idx;
  logic [TIME_W-1:0]   old_time;
  logic [SLOT_W-1:0]   sel;
  logic                alloc;

  logic [TOTAL_W-1:0]  emit_total;
  logic [IDX_W-1:0]    emit_idx;
  logic [HANDLE_W-1:0] rd_data;

  logic [HANDLE_W-1:0] mem [SLOTS*MAX_FRAG];

  logic                out_valid;
  status_t             out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [IDX_W-1:0]    out_idx;
  logic [HANDLE_W-1:0] out_handle;
  logic                out_last;

  cell_cmd_t           cmd;
  cell_stat_t          stat [SLOTS];
  cell_stat_t          cur;
  cell_stat_t          selst;
  logic                accept;
  logic                bad_seq;
  logic                scan_done;

  // Input field decode
  logic [5:0] f_seq;
  logic [5:0] f_total;
  assign f_seq   = s_axis_tdata[133:128];
  assign f_total = s_axis_tdata[139:134];
  assign bad_seq = (f_seq == 6'd0) || (f_seq > 6'(MAX_FRAG));

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {6'd0, out_handle, out_idx, out_slot, out_status};

  // Slot cells
  always_comb begin
    cmd.expire   = (state == S_EXPIRE);
    cmd.update   = (state == S_UPDATE);
    cmd.alloc    = alloc;
    cmd.total_ok = in_total_ok;
    cmd.total_in = in_total;
    cmd.frag_bit = MAX_FRAG'(1) << in_idx;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    fra_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (sel == SLOT_W'(g)),
      .key_reg  (in_reg),
      .key_conv (in_conv),
      .now      (in_now),
      .timeout  (timeout),
      .stat     (stat[g])
    );
  end

  assign cur       = stat[scan];
  assign selst     = stat[sel];
  assign scan_done = (scan == SLOT_W'(SLOTS - 1));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (accept) state_next = bad_seq ? S_WAIT : S_EXPIRE;
      S_EXPIRE:  state_next = S_SCAN;
      S_SCAN:    if (cur.match || scan_done) state_next = S_UPDATE;
      S_UPDATE:  state_next = (!selst.dup && selst.complete) ? S_EMIT_RD : S_WAIT;
      S_EMIT_RD: state_next = S_EMIT_LD;
      S_EMIT_LD: state_next = S_WAIT;
      S_WAIT: begin
        if (m_axis_tready) state_next = out_last ? S_IDLE : S_EMIT_RD;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst)            timeout <= TIMEOUT_RESET;
    else if (cfg_valid) timeout <= cfg_data;
  end

  // Latch the fragment
  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg      <= s_axis_tdata[63:0];
      in_conv     <= s_axis_tdata[127:64];
      in_idx      <= IDX_W'(f_seq - 6'd1);
      in_total_ok <= (f_total != 6'd0) && (f_total <= 6'(MAX_FRAG));
      in_total    <= f_total;
      in_handle   <= s_axis_tdata[155:140];
      in_now      <= s_axis_tdata[203:156];
    end
  end

  // Walk the slots: hit, else first free, else oldest
  always_ff @(posedge clk) begin
    if (state == S_EXPIRE) begin
      scan       <= '0;
      have_empty <= 1'b0;
      have_old   <= 1'b0;
      sel        <= '0;
      alloc      <= 1'b0;
    end else if (state == S_SCAN) begin
      if (cur.match) begin
        sel   <= scan;
        alloc <= 1'b0;
      end else begin
        if (!cur.valid) begin
          if (!have_empty) begin
            have_empty <= 1'b1;
            empty_idx  <= scan;
          end
        end else if (!have_old || cur.first_time < old_time) begin
          have_old <= 1'b1;
          old_idx  <= scan;
          old_time <= cur.first_time;
        end
        if (scan_done) begin
          alloc <= 1'b1;
          if (have_empty)      sel <= empty_idx;
          else if (!cur.valid) sel <= scan;
          else if (!have_old || cur.first_time < old_time) sel <= scan;
          else                 sel <= old_idx;
        end
        scan <= scan + SLOT_W'(1);
      end
    end
  end

  // Handle memory
  always_ff @(posedge clk) begin
    if (state == S_UPDATE && !selst.dup) mem[{sel, in_idx}] <= in_handle;
    if (state == S_EMIT_RD)              rd_data <= mem[{sel, emit_idx}];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && bad_seq) begin
            out_valid  <= 1'b1;
            out_status <= ST_ERROR;
            out_slot   <= '0;
            out_idx    <= '0;
            out_handle <= '0;
            out_last   <= 1'b1;
          end
        end
        S_UPDATE: begin
          emit_total <= selst.new_total;
          emit_idx   <= '0;
          if (selst.dup || !selst.complete) begin
            out_valid  <= 1'b1;
            out_status <= selst.dup ? ST_DUPLICATE : ST_PROGRESS;
            out_slot   <= sel;
            out_idx    <= '0;
            out_handle <= '0;
            out_last   <= 1'b1;
          end
        end
        S_EMIT_LD: begin
          out_valid  <= 1'b1;
          out_status <= ST_COMPLETE;
          out_slot   <= sel;
          out_idx    <= emit_idx;
          out_handle <= rd_data;
          out_last   <= ({1'b0, emit_idx} + TOTAL_W'(1)) == emit_total;
        end
        S_WAIT: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            emit_idx  <= emit_idx + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/fra_cell.sv @@
// ----------------------------------------------------------------------------
// fra_cell
// One table slot: keys, first time, total and presence mask.
// ----------------------------------------------------------------------------
`default_nettype none
module fra_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire fra_pkg::cell_cmd_t           cmd,
  input  wire logic                         sel,
  input  wire logic [fra_pkg::KEY_W-1:0]    key_reg,
  input  wire logic [fra_pkg::KEY_W-1:0]    key_conv,
  input  wire logic [fra_pkg::TIME_W-1:0]   now,
  input  wire logic [fra_pkg::TMO_W-1:0]    timeout,
  output fra_pkg::cell_stat_t               stat
);
  import fra_pkg::*;

  logic                valid;
  logic [TOTAL_W-1:0]  total;
  logic [MAX_FRAG-1:0] present;
  logic [KEY_W-1:0]    reg_key;
  logic [KEY_W-1:0]    conv_key;
  logic [TIME_W-1:0]   first_time;

  logic [TIME_W-1:0]   age;
  logic                expired;
  logic [MAX_FRAG-1:0] base_present;
  logic [TOTAL_W-1:0]  base_total;
  logic [TOTAL_W-1:0]  new_total;
  logic [MAX_FRAG-1:0] new_present;
  logic [MAX_FRAG-1:0] need;
  logic                dup;
  logic                complete;

  // Age check against the timeout
  always_comb begin
    age     = now - first_time;
    expired = valid && (now >= first_time) && (age > {{(TIME_W-TMO_W){1'b0}}, timeout});
  end

  // Merge the incoming fragment into this slot
  always_comb begin
    base_present = cmd.alloc ? '0 : present;
    base_total   = cmd.alloc ? '0 : total;
    new_total    = cmd.total_ok ? cmd.total_in : base_total;
    dup          = |(base_present & cmd.frag_bit);
    new_present  = base_present | cmd.frag_bit;
    need         = ~({MAX_FRAG{1'b1}} << new_total);
    complete     = !dup && (new_total != '0) && ((new_present & need) == need);
  end

  always_comb begin
    stat.valid      = valid;
    stat.match      = valid && (reg_key == key_reg) && (conv_key == key_conv);
    stat.first_time = first_time;
    stat.dup        = dup;
    stat.complete   = complete;
    stat.new_total  = new_total;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      total   <= '0;
      present <= '0;
    end else if (cmd.expire && expired) begin
      valid   <= 1'b0;
      total   <= '0;
      present <= '0;
    end else if (cmd.update && sel) begin
      if (complete) begin
        valid   <= 1'b0;
        total   <= '0;
        present <= '0;
      end else begin
        valid   <= 1'b1;
        total   <= new_total;
        present <= new_present;
      end
    end
  end

  // Keys and first time on allocation
  always_ff @(posedge clk) begin
    if (cmd.update && sel && cmd.alloc) begin
      reg_key    <= key_reg;
      conv_key   <= key_conv;
      first_time <= now;
    end
  end

endmodule
`default_nettype wire
